FILE: hw/rtl/aes128_block_cipher_defines.svh
// assertion macros for the block cipher
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define AES_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define AES_ASSERT_IMP(lbl, clk, rstn, a, c)
`define AES_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

FILE: hw/rtl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;
    localparam int RoundCount = 10;
    localparam int KeyDepth = 4 * (RoundCount + 1);
    localparam int KeyAw = $clog2(KeyDepth);

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef logic [7:0] byte_t;

    function automatic byte_t xtime(input byte_t a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gmul(input byte_t a, input byte_t b);
        byte_t p;
        byte_t x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    function automatic byte_t ginv(input byte_t a);
        byte_t r;
        byte_t sq;
        r = 8'h01;
        sq = a;
        for (int i = 0; i < 8; i++)
        begin
            if (i != 0)
                r = gmul(r, sq);
            sq = gmul(sq, sq);
        end
        ginv = r;
    endfunction

    function automatic byte_t rotl(input byte_t x, input int n);
        rotl = byte_t'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic byte_t sbox_fn(input byte_t a);
        byte_t x;
        x = ginv(a);
        sbox_fn = x ^ rotl(x, 1) ^ rotl(x, 2) ^ rotl(x, 3) ^ rotl(x, 4) ^ 8'h63;
    endfunction

    function automatic byte_t inv_sbox_fn(input byte_t a);
        inv_sbox_fn = ginv(rotl(a, 1) ^ rotl(a, 3) ^ rotl(a, 6) ^ 8'h05);
    endfunction

    typedef byte_t sbox_tab_t [256];

    function automatic sbox_tab_t make_sbox(input logic inv);
        sbox_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = inv ? inv_sbox_fn(byte_t'(i)) : sbox_fn(byte_t'(i));
        end
        make_sbox = t;
    endfunction

    localparam sbox_tab_t SBOX = make_sbox(1'b0);
    localparam sbox_tab_t INV_SBOX = make_sbox(1'b1);

    // control from sequencer to round unit
    typedef struct packed {
        logic load;
        logic inv;
        logic first;
        logic last;
    } round_ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/aes_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 44
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output      logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/aes_round.sv
`timescale 1ns / 1ps
`default_nettype none
// one shared round: state register, key column add, substitution, shift, mix
module aes_round
    import aes_pkg::*;
(
    input  wire logic         clk,
    input  wire round_ctl_t   ctl,
    input  wire logic [127:0] block_in,
    input  wire logic [127:0] rkey,
    output      logic [127:0] state
);
    logic [127:0] state_reg;
    logic [127:0] state_next;
    byte_t        s   [16];
    byte_t        sub [16];
    byte_t        sh  [16];
    byte_t        mx  [16];
    byte_t        ak  [16];
    byte_t        k   [16];
    byte_t        res [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_reg[127-8*i -: 8];
            k[i] = rkey[127-8*i -: 8];
        end
        // forward: sub, shift, mix, key
        // inverse: shift, sub, key, mix
        for (int i = 0; i < 16; i++)
        begin
            sub[i] = ctl.inv ? INV_SBOX[s[i]] : SBOX[s[i]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (ctl.inv)
                    sh[((c + r) % 4) * 4 + r] = INV_SBOX[s[c*4+r]];
                else
                    sh[c*4+r] = sub[((c + r) % 4) * 4 + r];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            ak[i] = sh[i] ^ k[i];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (ctl.inv)
                    mx[c*4+r] = gmul(8'h0e, ak[c*4+r]) ^ gmul(8'h0b, ak[c*4+(r+1)%4])
                              ^ gmul(8'h0d, ak[c*4+(r+2)%4]) ^ gmul(8'h09, ak[c*4+(r+3)%4]);
                else
                    mx[c*4+r] = gmul(8'h02, sh[c*4+r]) ^ gmul(8'h03, sh[c*4+(r+1)%4])
                              ^ sh[c*4+(r+2)%4] ^ sh[c*4+(r+3)%4];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (ctl.inv)
                res[i] = ctl.last ? ak[i] : mx[i];
            else
                res[i] = ctl.last ? ak[i] : (mx[i] ^ k[i]);
        end
        for (int i = 0; i < 16; i++)
        begin
            state_next[127-8*i -: 8] = ctl.first ? (s[i] ^ k[i]) : res[i];
        end
        if (ctl.load)
            state_next = block_in;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/aes128_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// aes-128 engine with a store of 44 pre-expanded round-key words
// command channel: a word is taken when start is high and busy is low
//   command 0 loads key_word at key_index, no result
//   command 1 encrypts, command 2 decrypts the block on block_hi/block_lo
//   command 3 is dropped
// result channel: out_hi, out_lo and was_decrypt are valid for one cycle
//   while done is high; the receiver cannot stall, so a result is never held
// a cipher word runs in order: the accepting cycle latches the block and
//   fetches the first key row, then come the initial key add, the ten
//   rounds and the output register; busy drops with done, so a new word
//   can be taken in the done cycle, but not while busy is high. the pace
//   is set by the one shared round unit, which does one round per cycle,
//   and the single shared read address of the key store
// the key store reads four words a cycle as four ram banks, one per column
// reset clears control state only; key words are undefined until loaded
module aes128_block_cipher
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  command,
    input  wire logic [5:0]  key_index,
    input  wire logic [31:0] key_word,
    input  wire logic [63:0] block_hi,
    input  wire logic [63:0] block_lo,
    output      logic        done,
    output      logic [63:0] out_hi,
    output      logic [63:0] out_lo,
    output      logic        was_decrypt
);
`include "aes128_block_cipher_defines.svh"

    localparam int RowAw = $clog2(RoundCount + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t           st_reg, st_next;
    logic [RowAw-1:0] rnd_reg, rnd_next;
    logic             inv_reg, inv_next;
    logic             first_reg, first_next;
    logic             done_reg;
    logic [127:0]     res_reg;
    logic [127:0]     blk;
    logic [127:0]     rkey;
    logic [RowAw-1:0] raddr;
    logic             accept;
    logic             is_cipher;
    logic             wr_ok;
    round_ctl_t       ctl;

    assign accept    = start && !busy;
    assign is_cipher = (cmd_t'(command) == CMD_ENC) || (cmd_t'(command) == CMD_DEC);
    assign wr_ok     = accept && (cmd_t'(command) == CMD_LOAD)
                       && (key_index < 6'(KeyDepth));
    assign busy      = (st_reg != ST_IDLE);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        aes_ram #(.Width(32), .Depth(RoundCount + 1)) u_ram (
            .clk   (clk),
            .we    (wr_ok && (key_index[1:0] == 2'(b))),
            .waddr (RowAw'(key_index >> 2)),
            .wdata (key_word),
            .raddr (raddr),
            .rdata (rkey[127-32*b -: 32])
        );
    end

    // round row fetched this cycle is used next cycle
    always_comb
    begin
        st_next    = st_reg;
        rnd_next   = rnd_reg;
        inv_next   = inv_reg;
        first_next = 1'b0;
        raddr      = rnd_reg;
        case (st_reg)
            ST_IDLE:
            begin
                inv_next = (cmd_t'(command) == CMD_DEC);
                raddr    = (cmd_t'(command) == CMD_DEC) ? RowAw'(RoundCount) : '0;
                if (accept && is_cipher)
                begin
                    st_next    = ST_RUN;
                    first_next = 1'b1;
                    rnd_next   = (cmd_t'(command) == CMD_DEC) ? RowAw'(RoundCount - 1)
                                                              : RowAw'(1);
                end
            end
            ST_RUN:
            begin
                if (inv_reg)
                begin
                    if (rnd_reg == '0 && !first_reg)
                        st_next = ST_OUT;
                    else if (!first_reg)
                        rnd_next = rnd_reg - 1'b1;
                end
                else
                begin
                    if (rnd_reg == RowAw'(RoundCount) && !first_reg)
                        st_next = ST_OUT;
                    else if (!first_reg)
                        rnd_next = rnd_reg + 1'b1;
                end
                // fetch the row for the round after this one
                raddr = rnd_next;
            end
            ST_OUT:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // key row in rkey belongs to the round applied in this cycle
    logic [RowAw-1:0] used_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            rnd_reg   <= '0;
            inv_reg   <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            used_reg  <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            rnd_reg   <= rnd_next;
            inv_reg   <= inv_next;
            first_reg <= first_next;
            done_reg  <= (st_reg == ST_OUT);
            used_reg  <= raddr;
        end
    end

    assign blk       = {block_hi, block_lo};
    assign ctl.load  = (st_reg == ST_IDLE);
    assign ctl.inv   = inv_reg;
    assign ctl.first = first_reg;
    assign ctl.last  = inv_reg ? (used_reg == '0) : (used_reg == RowAw'(RoundCount));

    logic [127:0] rstate;
    aes_round u_round (
        .clk      (clk),
        .ctl      (ctl),
        .block_in (blk),
        .rkey     (rkey),
        .state    (rstate)
    );

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_OUT)
            res_reg <= rstate;
    end

    logic dec_out_reg;
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_OUT)
            dec_out_reg <= inv_reg;
    end

    assign done        = done_reg;
    assign out_hi      = res_reg[127:64];
    assign out_lo      = res_reg[63:0];
    assign was_decrypt = dec_out_reg;

    `AES_ASSERT_NEXT(a_done_after_out, clk, rst_n, st_reg == ST_OUT, done_reg)
    `AES_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, st_reg == ST_IDLE)
    `AES_ASSERT_IMP(a_first_run, clk, rst_n, first_reg, st_reg == ST_RUN)
    `AES_ASSERT_NEXT(a_cipher_starts, clk, rst_n, accept && is_cipher, first_reg)
endmodule
`default_nettype wire
